@@ src/tkdp_pkg.sv @@
// Package for the top-K dot-product search block: payload structs, field widths,
// mode codes and the handoff structs between the front, multiply-accumulate and rank units.
// No dependencies.
`default_nettype none
package tkdp_pkg;

   localparam int TOP_K_DEF      = 32;
   localparam int VECTOR_DIM_DEF = 256;
   localparam int INDEX_BITS_DEF = 20;

   localparam int MODE_W     = 2;
   localparam int ELEM_IDX_W = 8;
   localparam int ELEM_W     = 16;
   localparam int RANK_W     = 6;
   localparam int CAND_IDX_W = 20;
   localparam int SCORE_W    = 40;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int IDX_EXT_W  = 24;

   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CAND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EMIT = 2'd2;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic [ELEM_IDX_W-1:0]    element_index;
      logic signed [ELEM_W-1:0] element_value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0]         rank;
      logic                      slot_filled;
      logic [CAND_IDX_W-1:0]     candidate_index;
      logic signed [SCORE_W-1:0] score;
      logic                      last_result;
   } rsp_type;

   // queued command, already classified
   typedef struct packed {
      logic [MODE_W-1:0]        op;
      logic [ELEM_IDX_W-1:0]    addr;
      logic signed [ELEM_W-1:0] value;
      logic                     last;
      logic                     in_range;
   } cmd_type;

   // back end to rank unit
   typedef struct packed {
      logic                      valid;
      logic                      emit;
      logic signed [SCORE_W-1:0] score;
   } score_type;

endpackage
`default_nettype wire

@@ src/tkdp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tkdp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/tkdp_front.sv @@
// Front end: accepts request transfers, classifies them into commands and holds
// them in a two-entry queue for the back end. Depends on tkdp_pkg.
`default_nettype none
module tkdp_front #(
   parameter int VECTOR_DIM = tkdp_pkg::VECTOR_DIM_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tkdp_pkg::req_type req_data,
   output logic                   cmd_valid,
   output tkdp_pkg::cmd_type      cmd,
   input  wire logic              cmd_pop
);
   import tkdp_pkg::*;

   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RANGE_W = ELEM_IDX_W + 1;

   cmd_type          q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             in_range;
   logic             keep;
   logic             push;
   cmd_type          new_cmd;

   assign in_range = RANGE_W'(req_data.element_index) < RANGE_W'(VECTOR_DIM);

   always_comb begin
      unique case (req_data.mode)
         MODE_LOAD: keep = in_range;
         MODE_CAND: keep = 1'b1;
         MODE_EMIT: keep = 1'b1;
         default:   keep = 1'b0;
      endcase
   end

   assign new_cmd.op       = req_data.mode;
   assign new_cmd.addr     = req_data.element_index;
   assign new_cmd.value    = req_data.element_value;
   assign new_cmd.last     = req_data.last_element;
   assign new_cmd.in_range = in_range;

   assign req_ready = count_ff != CNT_W'(DEPTH);
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(cmd_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

@@ src/tkdp_mac.sv @@
// Back end: query store, multiply stage and saturating 40-bit accumulator.
// Depends on tkdp_pkg and tkdp_ram.
`default_nettype none
module tkdp_mac #(
   parameter int VECTOR_DIM = tkdp_pkg::VECTOR_DIM_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire tkdp_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   input  wire logic              rank_busy,
   output tkdp_pkg::score_type    ins
);
   import tkdp_pkg::*;

   localparam int AW = $clog2(VECTOR_DIM);

   logic                      wr_en, rd_en;
   logic [AW-1:0]             ram_addr;
   logic [ELEM_W-1:0]         q_rd;
   logic                      pipe_empty;

   logic                      s1_valid_ff;
   logic signed [ELEM_W-1:0]  s1_value_ff;
   logic                      s1_last_ff;
   logic                      s1_in_range_ff;

   logic                      s2_valid_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff, s2_prod_in;
   logic                      s2_last_ff;

   logic signed [SCORE_W-1:0] acc_ff, acc_in;
   logic [SCORE_W:0]          sum;
   logic signed [SCORE_W-1:0] sat;

   assign pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign cmd_pop    = cmd_valid && !rank_busy && (cmd.op != MODE_EMIT || pipe_empty);
   assign wr_en      = cmd_pop && cmd.op == MODE_LOAD;
   assign rd_en      = cmd_pop && cmd.op == MODE_CAND;
   assign ram_addr   = cmd.addr[AW-1:0];

   tkdp_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(VECTOR_DIM)
   ) u_query (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ram_addr),
      .wr_data(cmd.value),
      .rd_en  (rd_en),
      .rd_addr(ram_addr),
      .rd_data(q_rd)
   );

   assign s2_prod_in = s1_in_range_ff ? PROD_W'($signed(q_rd) * s1_value_ff) : '0;

   assign sum = {acc_ff[SCORE_W-1], acc_ff}
              + {{(SCORE_W + 1 - PROD_W){s2_prod_ff[PROD_W-1]}}, s2_prod_ff};

   always_comb begin
      if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         sat = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sat = sum[SCORE_W-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_last_ff ? '0 : sat;
      end
   end

   assign ins.valid = s2_valid_ff && s2_last_ff;
   assign ins.emit  = cmd_pop && cmd.op == MODE_EMIT;
   assign ins.score = sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff    <= cmd.value;
      s1_last_ff     <= cmd.last;
      s1_in_range_ff <= cmd.in_range;
      s2_prod_ff     <= s2_prod_in;
      s2_last_ff     <= s1_last_ff;
   end

endmodule
`default_nettype wire

@@ src/tkdp_rank.sv @@
// Rank unit: sorted cell chain of the best scores, candidate counter and the
// emit sequencer with its output register. Depends on tkdp_pkg.
`default_nettype none
module tkdp_rank #(
   parameter int TOP_K      = tkdp_pkg::TOP_K_DEF,
   parameter int INDEX_BITS = tkdp_pkg::INDEX_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tkdp_pkg::score_type ins,
   output logic                     busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output tkdp_pkg::rsp_type        rsp_data
);
   import tkdp_pkg::*;

   logic                      valid_ff [TOP_K];
   logic signed [SCORE_W-1:0] score_ff [TOP_K];
   logic [INDEX_BITS-1:0]     idx_ff   [TOP_K];
   logic [TOP_K-1:0]          ge;

   logic [INDEX_BITS-1:0]     cnt_ff;
   logic                      emitting_ff;
   logic [RANK_W-1:0]         slot_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      load;
   logic [IDX_EXT_W-1:0]      idx_ext;

   assign load = emitting_ff && (!rsp_valid_ff || rsp_ready);

   for (genvar k = 0; k < TOP_K; k++) begin : g_cell
      logic                      take_new, take_prev;
      logic                      prev_valid, up_valid;
      logic signed [SCORE_W-1:0] prev_score, up_score;
      logic [INDEX_BITS-1:0]     prev_idx, up_idx;

      assign ge[k] = valid_ff[k] && (score_ff[k] >= ins.score);

      if (k == 0) begin : g_head
         assign take_new   = ins.valid && !ge[k];
         assign take_prev  = 1'b0;
         assign prev_valid = 1'b0;
         assign prev_score = ins.score;
         assign prev_idx   = cnt_ff;
      end else begin : g_body
         assign take_new   = ins.valid && !ge[k] && ge[k-1];
         assign take_prev  = ins.valid && !ge[k] && !ge[k-1];
         assign prev_valid = valid_ff[k-1];
         assign prev_score = score_ff[k-1];
         assign prev_idx   = idx_ff[k-1];
      end

      if (k == TOP_K - 1) begin : g_tail
         assign up_valid = 1'b0;
         assign up_score = '0;
         assign up_idx   = '0;
      end else begin : g_mid
         assign up_valid = valid_ff[k+1];
         assign up_score = score_ff[k+1];
         assign up_idx   = idx_ff[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            priority if (load) begin
               valid_ff[k] <= up_valid;
            end else if (take_new) begin
               valid_ff[k] <= 1'b1;
            end else if (take_prev) begin
               valid_ff[k] <= prev_valid;
            end
         end
      end

      always_ff @(posedge clock) begin
         priority if (load) begin
            score_ff[k] <= up_score;
            idx_ff[k]   <= up_idx;
         end else if (take_new) begin
            score_ff[k] <= ins.score;
            idx_ff[k]   <= cnt_ff;
         end else if (take_prev) begin
            score_ff[k] <= prev_score;
            idx_ff[k]   <= prev_idx;
         end
      end
   end

   assign idx_ext = IDX_EXT_W'(idx_ff[0]);

   assign rsp_in.rank            = slot_ff;
   assign rsp_in.slot_filled     = valid_ff[0];
   assign rsp_in.candidate_index = valid_ff[0] ? idx_ext[CAND_IDX_W-1:0] : '0;
   assign rsp_in.score           = valid_ff[0] ? score_ff[0] : '0;
   assign rsp_in.last_result     = slot_ff == RANK_W'(TOP_K - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         emitting_ff  <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ins.emit) begin
            cnt_ff <= '0;
         end else if (ins.valid) begin
            cnt_ff <= cnt_ff + 1'b1;
         end

         if (ins.emit) begin
            emitting_ff <= 1'b1;
            slot_ff     <= '0;
         end else if (load) begin
            slot_ff <= slot_ff + 1'b1;
            if (rsp_in.last_result) begin
               emitting_ff <= 1'b0;
            end
         end

         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = emitting_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ src/top_k_dot_product_search.sv @@
// Top level of the top-K dot-product search block: front queue, multiply-accumulate
// back end and rank unit. Depends on tkdp_pkg, tkdp_front, tkdp_mac, tkdp_rank.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (tkdp_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (tkdp_pkg::rsp_type)
//
// Query loads and candidate elements are taken one per cycle through a two-entry queue
// while no emit is pending or running. A candidate score is ranked after its last element
// passes the query read register and the product register; the cell chain then inserts it.
// An emit waits for the multiply pipeline to drain, then sends TOP_K transfers, one per
// cycle while rsp_ready is high; items behind it wait until the last slot is loaded.
// Synchronous reset clears list, counter, accumulator and queue; the query store
// keeps its contents.
`default_nettype none
module top_k_dot_product_search #(
   parameter int TOP_K      = tkdp_pkg::TOP_K_DEF,
   parameter int VECTOR_DIM = tkdp_pkg::VECTOR_DIM_DEF,
   parameter int INDEX_BITS = tkdp_pkg::INDEX_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tkdp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tkdp_pkg::rsp_type      rsp_data
);
   import tkdp_pkg::*;

   logic      cmd_valid;
   cmd_type   cmd;
   logic      cmd_pop;
   logic      rank_busy;
   score_type ins;

   tkdp_front #(
      .VECTOR_DIM(VECTOR_DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   tkdp_mac #(
      .VECTOR_DIM(VECTOR_DIM)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rank_busy(rank_busy),
      .ins      (ins)
   );

   tkdp_rank #(
      .TOP_K     (TOP_K),
      .INDEX_BITS(INDEX_BITS)
   ) u_rank (
      .clock    (clock),
      .reset    (reset),
      .ins      (ins),
      .busy     (rank_busy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   a_no_insert_during_emit: assert property (@(posedge clock) disable iff (reset)
      ins.valid |-> !rank_busy && !ins.emit)
      else $error("score insert while list is being emitted");

   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      ins.emit |=> rank_busy)
      else $error("emit accepted but sequencer not running");

   a_emit_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_result |=> rsp_valid)
      else $error("gap inside an emitted list");

   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |-> rsp_data.rank == RANK_W'(TOP_K - 1))
      else $error("last result flagged on wrong rank");

endmodule
`default_nettype wire

@@ bench/tb_top_k_dot_product_search.sv @@
// Testbench for top_k_dot_product_search: directed and random query loads, candidate
// vectors and emits, with each result transfer checked against a built-in top-K predictor.
// Depends on tkdp_pkg and top_k_dot_product_search.
module tb_top_k_dot_product_search;
   import tkdp_pkg::*;

   localparam int CLK_PERIOD = 20;
   localparam int LIST_LEN   = TOP_K_DEF;
   localparam int RAND_ITEMS = 40;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   top_k_dot_product_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predictor state
   bit signed [ELEM_W-1:0]  query_copy [256];
   bit                      query_written [256];
   int                      known_idx [$];
   bit signed [SCORE_W-1:0] dot_acc;
   bit [CAND_IDX_W-1:0]     arrival_count;
   bit signed [SCORE_W-1:0] best_score [LIST_LEN];
   bit [CAND_IDX_W-1:0]     best_cand [LIST_LEN];
   bit                      best_used [LIST_LEN];
   rsp_type                 slot_queue [$];

   bit      idle_on;
   int      sent_count;
   int      error_count;
   rsp_type want;

   always begin
      clock = 1'b0;
      #(CLK_PERIOD / 2);
      clock = 1'b1;
      #(CLK_PERIOD / 2);
   end

   function automatic void apply_item(input req_type item);
      logic signed [PROD_W-1:0]  prod;
      logic signed [SCORE_W+1:0] sum;
      rsp_type                   slot;
      int                        pos;
      case (item.mode)
         MODE_LOAD: begin
            if (int'(item.element_index) < VECTOR_DIM_DEF) begin
               if (!query_written[item.element_index])
                  known_idx.push_back(int'(item.element_index));
               query_written[item.element_index] = 1'b1;
               query_copy[item.element_index] = item.element_value;
            end
         end
         MODE_CAND: begin
            prod = '0;
            if (int'(item.element_index) < VECTOR_DIM_DEF)
               prod = PROD_W'($signed(query_copy[item.element_index]))
                    * PROD_W'($signed(item.element_value));
            sum = (SCORE_W+2)'(dot_acc) + (SCORE_W+2)'(prod);
            if (sum > SCORE_MAX)
               dot_acc = SCORE_MAX;
            else if (sum < SCORE_MIN)
               dot_acc = SCORE_MIN;
            else
               dot_acc = sum[SCORE_W-1:0];
            if (item.last_element) begin
               pos = 0;
               while (pos < LIST_LEN && best_used[pos] && best_score[pos] >= dot_acc)
                  pos++;
               if (pos < LIST_LEN) begin
                  for (int k = LIST_LEN - 1; k > pos; k--) begin
                     best_score[k] = best_score[k-1];
                     best_cand[k]  = best_cand[k-1];
                     best_used[k]  = best_used[k-1];
                  end
                  best_score[pos] = dot_acc;
                  best_cand[pos]  = arrival_count;
                  best_used[pos]  = 1'b1;
               end
               arrival_count++;
               dot_acc = '0;
            end
         end
         MODE_EMIT: begin
            for (int k = 0; k < LIST_LEN; k++) begin
               slot.rank            = RANK_W'(k);
               slot.slot_filled     = best_used[k];
               slot.candidate_index = best_used[k] ? best_cand[k] : '0;
               slot.score           = best_used[k] ? best_score[k] : '0;
               slot.last_result     = (k == LIST_LEN - 1);
               slot_queue.push_back(slot);
            end
            for (int k = 0; k < LIST_LEN; k++) begin
               best_score[k] = '0;
               best_cand[k]  = '0;
               best_used[k]  = 1'b0;
            end
            arrival_count = '0;
         end
         default: ;
      endcase
   endfunction

   task automatic report_error(input string field, input logic [SCORE_W-1:0] got,
                               input logic [SCORE_W-1:0] exp_val);
      error_count++;
      if (error_count <= 50)
         $display("mismatch: %s got %0h expected %0h", field, got, exp_val);
   endtask

   // result checker: rsp side is stable from negedge to the transfer edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (slot_queue.size() == 0) begin
            report_error("unexpected transfer, rank", SCORE_W'(rsp_data.rank), '0);
         end else begin
            want = slot_queue.pop_front();
            if (rsp_data.rank !== want.rank)
               report_error("rank", SCORE_W'(rsp_data.rank), SCORE_W'(want.rank));
            if (rsp_data.slot_filled !== want.slot_filled)
               report_error("slot_filled", SCORE_W'(rsp_data.slot_filled),
                            SCORE_W'(want.slot_filled));
            if (rsp_data.candidate_index !== want.candidate_index)
               report_error("candidate_index", SCORE_W'(rsp_data.candidate_index),
                            SCORE_W'(want.candidate_index));
            if (rsp_data.score !== want.score)
               report_error("score", rsp_data.score, want.score);
            if (rsp_data.last_result !== want.last_result)
               report_error("last_result", SCORE_W'(rsp_data.last_result),
                            SCORE_W'(want.last_result));
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input int idx, input int val,
                            input bit last);
      req_type item;
      bit      taken;
      item.mode          = mode;
      item.element_index = ELEM_IDX_W'(idx);
      item.element_value = ELEM_W'(val);
      item.last_element  = last;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      apply_item(item);
      if (mode != MODE_NONE)
         sent_count++;
   endtask

   function automatic int pick_index();
      return known_idx[$urandom_range(0, known_idx.size() - 1)];
   endfunction

   function automatic int pick_value(input bit pooled);
      if (!pooled)
         return $urandom_range(0, 65535);
      case ($urandom_range(0, 6))
         0:       return -32768;
         1:       return -16384;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 16384;
         default: return 32767;
      endcase
   endfunction

   task automatic send_candidate(input int length, input bit pooled);
      for (int e = 0; e < length; e++)
         send_item(MODE_CAND, pick_index(), pick_value(pooled), e == length - 1);
   endtask

   // stray items and broken vectors
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_item(MODE_NONE, $urandom, $urandom, 1'($urandom_range(0, 1)));
         1: send_item(MODE_LOAD, $urandom_range(0, 255), pick_value(1'b0),
                      1'($urandom_range(0, 1)));
         2: send_item(MODE_CAND, pick_index(), pick_value(1'b0), 1'b0);
         default: begin
            send_item(MODE_CAND, pick_index(), pick_value(1'b0), 1'b0);
            send_item(MODE_EMIT, $urandom, $urandom, 1'b1);
         end
      endcase
   endtask

   task automatic test_empty_list();
      send_item(MODE_EMIT, 0, 0, 1'b0);
      send_item(MODE_EMIT, 255, -1, 1'b1);
   endtask

   task automatic test_basic_ops();
      send_item(MODE_LOAD, 0, -32768, 1'b1);
      send_item(MODE_LOAD, 255, 32767, 1'b0);
      send_item(MODE_LOAD, 170, 16384, 1'b0);
      send_item(MODE_LOAD, 85, -1, 1'b1);
      send_item(MODE_CAND, 0, -32768, 1'b1);
      send_item(MODE_CAND, 255, 32767, 1'b0);
      send_item(MODE_CAND, 0, 32767, 1'b1);
      send_item(MODE_CAND, 170, 0, 1'b1);
      send_item(MODE_CAND, 85, 1, 1'b0);
      send_item(MODE_NONE, 255, -1, 1'b1);
      // emit inside an open vector keeps the partial sum
      send_item(MODE_EMIT, 0, 0, 1'b1);
      send_item(MODE_CAND, 85, 1, 1'b1);
      send_item(MODE_EMIT, 0, 0, 1'b0);
   endtask

   task automatic test_ties();
      send_item(MODE_CAND, 170, 2, 1'b1);
      send_item(MODE_CAND, 85, -32768, 1'b1);
      send_item(MODE_CAND, 170, 2, 1'b1);
      send_item(MODE_CAND, 255, 0, 1'b1);
      send_item(MODE_CAND, 170, 2, 1'b1);
      send_item(MODE_EMIT, 0, 0, 1'b0);
   endtask

   task automatic test_saturation();
      // query entry 0 holds -32768
      repeat (512) send_item(MODE_CAND, 0, -32768, 1'b0);
      send_item(MODE_CAND, 0, 32767, 1'b1);
      send_item(MODE_EMIT, 0, 0, 1'b0);
   endtask

   task automatic test_random_search();
      int goal;
      int n_cand;
      bit pooled;
      goal = sent_count + RAND_ITEMS;
      while (sent_count < goal) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pooled  = 1'($urandom_range(0, 1));
         repeat ($urandom_range(0, 4))
            send_item(MODE_LOAD, $urandom_range(0, 255), pick_value(pooled),
                      1'($urandom_range(0, 1)));
         n_cand = $urandom_range(0, 40);
         for (int c = 0; c < n_cand; c++) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            send_candidate(($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                        : $urandom_range(1, 3), pooled);
         end
         if ($urandom_range(0, 7) != 0)
            send_item(MODE_EMIT, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
      send_item(MODE_EMIT, $urandom, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (40) send_candidate($urandom_range(1, 2), 1'b1);
      send_item(MODE_EMIT, 0, 0, 1'b0);
      send_item(MODE_EMIT, 0, 0, 1'b1);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      idle_on     = 1'b1;
      sent_count  = 0;
      error_count = 0;
      dot_acc     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_basic_ops();
      test_ties();
      test_saturation();
      test_random_search();
      test_back_to_back();
      req_valid <= 1'b0;
      while (slot_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("[top_k_dot_product_search] OK");
      else
         $display("[top_k_dot_product_search] ERROR");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 400000);
      $display("[top_k_dot_product_search] ERROR");
      $finish;
   end

endmodule
